// ----- design/bole_pkg.sv -----
// Package with shared types, codes and constants of the bounded ordered list engine.
`timescale 1ns / 1ps

package bole_pkg;

  // Default sizes of the list storage.
  localparam int unsigned ListDepthDefault = 16;
  localparam int unsigned WordWidthDefault = 32;

  // Operation codes carried in the mode field; code 7 is a no-op.
  typedef enum logic [2:0] {
    MODE_INS_HEAD = 3'd0,
    MODE_INS_TAIL = 3'd1,
    MODE_INS_POS  = 3'd2,
    MODE_DEL_HEAD = 3'd3,
    MODE_DEL_TAIL = 3'd4,
    MODE_DEL_POS  = 3'd5,
    MODE_DUMP     = 3'd6
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Input beat: one list operation.
  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_beat_t;

  // Output beat: one result.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
    logic [4:0]         length;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new operation
    logic step;  // execute one step and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dump;    // held operation is a dump
    logic dump_last;  // next dump step emits the final beat
  } dp_status_t;

endpackage

// ----- design/bounded_ordered_list_engine_core.sv -----
// An accepted operation beat is held, and its result beat is registered when the output
// is free. One edit per cycle while results are taken; a dump emits one element per cycle
// while results are taken, from the head of a rotating shift-register list.
// An empty dump or any edit gives a single result beat.
// Reset (rst_ni low, asynchronous) empties the list; list words themselves are not cleared.
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core
  import bole_pkg::*;
#(
  parameter int unsigned ListDepth = ListDepthDefault,
  parameter int unsigned WordWidth = WordWidthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_beat_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequencer for handshakes and steps.
  bole_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  // List storage and result formation.
  bole_dp #(
    .ListDepth (ListDepth),
    .WordWidth (WordWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .dp_cmd_i    (dp_cmd),
    .dp_status_o (dp_status),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ----- design/bole_ctrl.sv -----
// Controller state machine of the bounded ordered list engine.
`timescale 1ns / 1ps

module bole_ctrl
  import bole_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t dp_status_i,
  output dp_cmd_t    dp_cmd_o
);

  typedef enum logic {
    CTRL_IDLE,
    CTRL_BUSY
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;
  logic        finish;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state, handshakes and datapath commands.
  always_comb begin
    out_free         = !out_valid_q || out_ready_i;
    dp_cmd_o.step    = (state_q == CTRL_BUSY) && out_free;
    finish           = dp_cmd_o.step && (!dp_status_i.is_dump || dp_status_i.dump_last);
    in_ready_o       = (state_q == CTRL_IDLE) || finish;
    dp_cmd_o.load    = in_valid_i && in_ready_o;
    state_d          = state_q;
    out_valid_d      = out_valid_q;
    if (dp_cmd_o.step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      CTRL_IDLE: begin
        if (dp_cmd_o.load) begin
          state_d = CTRL_BUSY;
        end
      end
      CTRL_BUSY: begin
        if (finish && !dp_cmd_o.load) begin
          state_d = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/bole_dp.sv -----
// Datapath of the bounded ordered list engine: shift-register list and result register.
`timescale 1ns / 1ps

module bole_dp
  import bole_pkg::*;
#(
  parameter int unsigned ListDepth = ListDepthDefault,
  parameter int unsigned WordWidth = WordWidthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_beat_t   in_beat_i,
  input  dp_cmd_t    dp_cmd_i,
  output dp_status_t dp_status_o,
  output out_beat_t  out_beat_o
);

  localparam int unsigned LenW = $clog2(ListDepth + 1);
  localparam int unsigned IdxW = $clog2(ListDepth);
  localparam int unsigned CmpW = ((LenW > 8) ? LenW : 8) + 1;

  // Held operation.
  logic [2:0]           mode_q;
  logic [WordWidth-1:0] word_q;
  logic [7:0]           pos_q;

  // List storage, entry 0 is the head; entries at or past the length are don't-care.
  logic [WordWidth-1:0] list_q [ListDepth];
  logic [WordWidth-1:0] list_d [ListDepth];
  logic [LenW-1:0]      len_q, len_d;
  logic [LenW-1:0]      dump_cnt_q, dump_cnt_d;
  out_beat_t            out_q, out_d;

  logic [CmpW-1:0]      pos_c, len_c;
  logic [LenW-1:0]      len_m1;
  logic [IdxW-1:0]      last_idx;
  logic [IdxW-1:0]      k_idx;
  logic                 do_ins, do_shift, do_rot;
  logic [1:0]           st;
  logic                 is_dump, dump_last;

  assign is_dump   = (mode_q == MODE_DUMP);
  assign len_m1    = len_q - LenW'(1);
  assign last_idx  = IdxW'(len_m1);
  assign dump_last = (len_q == '0) || (dump_cnt_q == len_m1);
  assign pos_c     = CmpW'(pos_q);
  assign len_c     = CmpW'(len_q);

  assign dp_status_o.is_dump   = is_dump;
  assign dp_status_o.dump_last = dump_last;

  // Operation decode: status, kind of edit and slot index.
  always_comb begin
    st       = ST_OK;
    do_ins   = 1'b0;
    do_shift = 1'b0;
    do_rot   = 1'b0;
    k_idx    = '0;
    len_d    = len_q;
    unique case (mode_q)
      MODE_INS_HEAD, MODE_INS_TAIL, MODE_INS_POS: begin
        if (len_q == LenW'(ListDepth)) begin
          st = ST_FULL;
        end else if (mode_q == MODE_INS_HEAD || len_q == '0) begin
          do_ins = 1'b1;
        end else if (mode_q == MODE_INS_TAIL) begin
          do_ins = 1'b1;
          k_idx  = IdxW'(len_q);
        end else if (pos_c >= CmpW'(1) && pos_c <= len_c + CmpW'(1)) begin
          do_ins = 1'b1;
          k_idx  = IdxW'(pos_c - CmpW'(1));
        end else begin
          st = ST_BADPOS;
        end
        if (do_ins) begin
          len_d = len_q + LenW'(1);
        end
      end
      MODE_DEL_HEAD, MODE_DEL_TAIL, MODE_DEL_POS: begin
        if (len_q == '0) begin
          st = ST_EMPTY;
        end else if (mode_q == MODE_DEL_HEAD) begin
          do_shift = 1'b1;
        end else if (mode_q == MODE_DEL_TAIL) begin
          do_shift = 1'b1;
          k_idx    = last_idx;
        end else if (pos_c >= CmpW'(1) && pos_c <= len_c) begin
          do_shift = 1'b1;
          k_idx    = IdxW'(pos_c - CmpW'(1));
        end else begin
          st = ST_BADPOS;
        end
        if (do_shift) begin
          len_d = len_m1;
        end
      end
      MODE_DUMP: begin
        // Rotate the list by one so the next element reaches the head.
        do_rot   = (len_q != '0);
        do_shift = do_rot;
        if (len_q == '0) begin
          st = ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // Next value of each list entry; each entry looks at its neighbors and the head.
  always_comb begin
    for (int unsigned i = 0; i < ListDepth; i++) begin
      list_d[i] = list_q[i];
      if (do_ins) begin
        if (IdxW'(i) == k_idx) begin
          list_d[i] = word_q;
        end else if (IdxW'(i) > k_idx) begin
          list_d[i] = list_q[(i > 0) ? i - 1 : 0];
        end
      end
      if (do_shift && IdxW'(i) >= k_idx && i < ListDepth - 1) begin
        list_d[i] = list_q[(i < ListDepth - 1) ? i + 1 : i];
      end
      if (do_rot && IdxW'(i) == last_idx) begin
        list_d[i] = list_q[0];
      end
    end
  end

  // Result beat for the current step.
  always_comb begin
    out_d         = out_q;
    out_d.status  = st;
    out_d.element = '0;
    out_d.last    = 1'b1;
    out_d.length  = 5'(len_d);
    dump_cnt_d    = dump_cnt_q;
    if (is_dump) begin
      out_d.length = 5'(len_q);
      if (len_q != '0) begin
        out_d.element = 32'(list_q[0]);
        out_d.last    = dump_last;
        dump_cnt_d    = dump_cnt_q + LenW'(1);
      end
    end
    if (dp_cmd_i.load) begin
      dump_cnt_d = '0;
    end
  end

  // Control registers: length and dump counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      dump_cnt_q <= '0;
    end else begin
      if (dp_cmd_i.step) begin
        len_q <= len_d;
      end
      if (dp_cmd_i.step || dp_cmd_i.load) begin
        dump_cnt_q <= dump_cnt_d;
      end
    end
  end

  // Payload registers: held operation, list words and result beat.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      mode_q <= in_beat_i.mode;
      word_q <= WordWidth'(in_beat_i.value);
      pos_q  <= in_beat_i.position;
    end
    if (dp_cmd_i.step) begin
      out_q <= out_d;
      for (int unsigned i = 0; i < ListDepth; i++) begin
        list_q[i] <= list_d[i];
      end
    end
  end

  assign out_beat_o = out_q;

endmodule
